// File: sv/rmbu_pkg.sv
// package for the raw matrix byte unpacker
// holds phase codes, word format codes, register indexes and the output flags struct
package rmbu_pkg;

    typedef enum logic [1:0] {
        PH_FILE = 2'd0,
        PH_ROW  = 2'd1,
        PH_DATA = 2'd2,
        PH_DONE = 2'd3
    } t_phase;

    localparam logic [1:0] FMT_INT16   = 2'd0;
    localparam logic [1:0] FMT_INT32   = 2'd1;
    localparam logic [1:0] FMT_FLOAT32 = 2'd2;

    localparam logic [2:0] REG_WORD_FORMAT = 3'd0;
    localparam logic [2:0] REG_BIG_ENDIAN  = 3'd1;
    localparam logic [2:0] REG_COMPLEX     = 3'd2;
    localparam logic [2:0] REG_FILE_HDR    = 3'd3;
    localparam logic [2:0] REG_ROW_HDR     = 3'd4;
    localparam logic [2:0] REG_ROW_POINTS  = 3'd5;
    localparam logic [2:0] REG_ROW_COUNT   = 3'd6;

    typedef struct packed {
        logic        is_imaginary;
        logic        row_end;
        logic        frame_end;
    } t_flags;

endpackage

// File: sv/rmbu_convert.sv
// converts an assembled word to float32 bits, combinational
// depends on rmbu_pkg
module rmbu_convert (
    input  logic [1:0]  i_format,
    input  logic [31:0] i_word,
    output logic [31:0] o_bits
);
    import rmbu_pkg::*;

    logic        neg;
    logic [31:0] mag;
    logic [4:0]  p;
    logic [31:0] norm;
    logic [24:0] mant;
    logic        guard;
    logic        sticky;
    logic        round_up;
    logic [7:0]  expo;

    always_comb begin
        neg = 1'b0;
        mag = i_word;
        if (i_format == FMT_INT16) begin
            neg = i_word[15];
            mag = neg ? (32'h0001_0000 - {16'd0, i_word[15:0]}) : {16'd0, i_word[15:0]};
        end else begin
            neg = i_word[31];
            mag = neg ? (~i_word + 32'd1) : i_word;
        end
        p = 5'd0;
        for (int k = 0; k < 32; k++) begin
            if (mag[k]) begin
                p = 5'(k);
            end
        end
        norm     = mag << (5'd31 - p);
        guard    = norm[7];
        sticky   = |norm[6:0];
        round_up = guard && (sticky || norm[8]);
        mant     = {1'b0, norm[31:8]} + {24'd0, round_up};
        expo     = 8'd127 + {3'd0, p} + {7'd0, mant[24]};
        if (i_format != FMT_INT16 && i_format != FMT_INT32) begin
            o_bits = i_word;
        end else if (mag == 32'd0) begin
            o_bits = 32'd0;
        end else if (mant[24]) begin
            o_bits = {neg, expo, mant[23:1]};
        end else begin
            o_bits = {neg, expo, mant[22:0]};
        end
    end
endmodule

// File: sv/raw_matrix_byte_unpacker_core.sv
// top level of the raw matrix byte unpacker
// depends on rmbu_pkg and rmbu_convert
// Takes one byte per clock with no gaps of its own: input beats go to an
// input register, then framing, word assembly and int to float32 conversion
// run in one stage into an output register. A beat passes through the input
// and output registers on its way to a sample; a sample can come out every
// word-size bytes. A stalled output holds the pipeline, the input takes a
// beat whenever the output register is empty or being drained.
module raw_matrix_byte_unpacker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_sample_bits,
    output logic        o_is_imaginary,
    output logic        o_row_end,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import rmbu_pkg::*;

    logic [1:0]  r_word_format;
    logic        r_big_endian;
    logic        r_complex;
    logic [23:0] r_file_hdr;
    logic [15:0] r_row_hdr;
    logic [16:0] r_row_points;
    logic [16:0] r_row_count;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_sof;

    logic [23:0] r_hdr_cnt,  n_hdr_cnt;
    logic [1:0]  r_biw,      n_biw;
    logic [31:0] r_shift,    n_shift;
    logic [16:0] r_col,      n_col;
    logic [16:0] r_row,      n_row;
    logic        r_imag,     n_imag;
    t_phase      r_phase,    n_phase;

    logic        r_out_valid;
    logic [31:0] r_out_bits;
    t_flags      r_out_flags;

    logic        advance;
    logic        emit;
    logic [31:0] word_done;
    logic [31:0] conv_bits;
    t_flags      flags;

    assign advance = !(r_out_valid && i_stall);
    assign o_stall = !advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_format <= FMT_FLOAT32;
            r_big_endian  <= 1'b0;
            r_complex     <= 1'b0;
            r_file_hdr    <= '0;
            r_row_hdr     <= '0;
            r_row_points  <= 17'd256;
            r_row_count   <= 17'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WORD_FORMAT: r_word_format <= i_cfg_data[1:0];
                REG_BIG_ENDIAN:  r_big_endian  <= i_cfg_data[0];
                REG_COMPLEX:     r_complex     <= i_cfg_data[0];
                REG_FILE_HDR:    r_file_hdr    <= i_cfg_data;
                REG_ROW_HDR:     r_row_hdr     <= i_cfg_data[15:0];
                REG_ROW_POINTS:  r_row_points  <= i_cfg_data[16:0];
                REG_ROW_COUNT:   r_row_count   <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [2:0] cnt;
        logic [2:0] wbytes;
        n_hdr_cnt = r_hdr_cnt;
        n_biw     = r_biw;
        n_shift   = r_shift;
        n_col     = r_col;
        n_row     = r_row;
        n_imag    = r_imag;
        n_phase   = r_phase;
        emit      = 1'b0;
        word_done = '0;
        flags     = '0;
        cnt       = '0;
        wbytes    = (r_word_format == FMT_INT16) ? 3'd2 : 3'd4;
        if (r_in_sof) begin
            n_hdr_cnt = '0;
            n_biw     = '0;
            n_shift   = '0;
            n_col     = '0;
            n_row     = '0;
            n_imag    = 1'b0;
            n_phase   = PH_FILE;
        end
        if (n_phase == PH_FILE && n_hdr_cnt >= r_file_hdr) begin
            n_phase   = PH_ROW;
            n_hdr_cnt = '0;
        end
        if (n_phase == PH_ROW && n_hdr_cnt >= {8'd0, r_row_hdr}) begin
            n_phase   = PH_DATA;
            n_hdr_cnt = '0;
        end
        priority if (n_phase == PH_FILE || n_phase == PH_ROW) begin
            n_hdr_cnt = n_hdr_cnt + 24'd1;
        end else if (n_phase == PH_DATA) begin
            if (r_big_endian) begin
                n_shift = {n_shift[23:0], r_in_byte};
            end else begin
                n_shift = n_shift | ({24'd0, r_in_byte} << {n_biw, 3'b000});
            end
            n_biw = n_biw + 2'd1;
            cnt   = {1'b0, n_biw};
            if (n_biw == 2'd0 || cnt >= wbytes) begin
                emit            = 1'b1;
                word_done       = n_shift;
                flags.is_imaginary = n_imag;
                n_shift         = '0;
                n_biw           = '0;
                if (r_complex && !n_imag) begin
                    n_imag = 1'b1;
                end else begin
                    n_imag = 1'b0;
                    if ({1'b0, n_col} + 18'd1 >= {1'b0, r_row_points}) begin
                        flags.row_end = 1'b1;
                        n_col = '0;
                        if ({1'b0, n_row} + 18'd1 >= {1'b0, r_row_count}) begin
                            flags.frame_end = 1'b1;
                            n_row   = '0;
                            n_phase = PH_DONE;
                        end else begin
                            n_row     = n_row + 17'd1;
                            n_phase   = PH_ROW;
                            n_hdr_cnt = '0;
                        end
                    end else begin
                        n_col = n_col + 17'd1;
                    end
                end
            end
        end else begin
            emit = 1'b0;
        end
    end

    rmbu_convert u_convert (
        .i_format (r_word_format),
        .i_word   (word_done),
        .o_bits   (conv_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hdr_cnt   <= '0;
            r_biw       <= '0;
            r_shift     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_imag      <= 1'b0;
            r_phase     <= PH_FILE;
        end else if (advance) begin
            r_in_valid  <= i_valid;
            r_out_valid <= r_in_valid && emit;
            if (r_in_valid) begin
                r_hdr_cnt <= n_hdr_cnt;
                r_biw     <= n_biw;
                r_shift   <= n_shift;
                r_col     <= n_col;
                r_row     <= n_row;
                r_imag    <= n_imag;
                r_phase   <= n_phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_in_byte <= i_data_byte;
            r_in_sof  <= i_start_of_file;
            if (r_in_valid && emit) begin
                r_out_bits  <= conv_bits;
                r_out_flags <= flags;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sample_bits  = r_out_bits;
    assign o_is_imaginary = r_out_flags.is_imaginary;
    assign o_row_end      = r_out_flags.row_end;
    assign o_frame_end    = r_out_flags.frame_end;

    a_frame_has_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_row_end) else $error("frame end without row end");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_sample_bits)) else $error("output lost");
    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in_sof && r_phase == PH_DONE |-> !emit) else $error("emit after done");
endmodule
